// ===== sv/brc_pkg.sv =====
package brc_pkg;

  // Field widths of the ports
  localparam int SIZE_W   = 13;
  localparam int INDEX_W  = 12;
  localparam int STRIDE_W = 4;
  localparam int POS_W    = 16;
  localparam int WEIGHT_W = 4;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;

  // Largest reference position the result field can carry
  localparam logic [POS_W-1:0] POS_SAT = 16'hFFFF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_SIZE  = 2'd0,
    CFG_DST_SIZE = 2'd1,
    CFG_STRIDE   = 2'd2
  } cfg_reg_t;

  // One finished result item
  typedef struct packed {
    logic [POS_W-1:0]    ref_pos;
    logic [WEIGHT_W-1:0] left_weight;
  } brc_result_t;

endpackage

// ===== sv/bilinear_resize_coeff_gen.sv =====
// Bilinear scaler coefficient generator: one output index in, one (ref_pos, left_weight) out.
// Pipeline from accepted item to out_valid: position multiply register, one divider cell
//   per quotient bit, reference/weight selection register, one output register.
// Throughput: one item per cycle while the skid slot is empty (in_stall low);
//   the divider is a chain of restoring cells, one bit each.
// Reset (synchronous, rst_n low): in_size = 8, destination size = 5, stride_factor = 1,
//   pipeline empty.
module bilinear_resize_coeff_gen #(
  parameter int SUBPIXEL_BITS = 3,
  parameter int MAX_SIZE      = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [brc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [brc_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [brc_pkg::INDEX_W-1:0]       in_out_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [brc_pkg::POS_W-1:0]         out_ref_pos,
  output logic [brc_pkg::WEIGHT_W-1:0]      out_left_weight
);

  localparam int S     = SUBPIXEL_BITS;
  localparam int PRE_W = brc_pkg::INDEX_W + S;
  localparam int NUM_W = PRE_W + brc_pkg::SIZE_W;
  localparam int REF_W = NUM_W - S;
  localparam int FULL  = 1 << S;
  localparam int HALF  = 1 << (S - 1);

  logic [brc_pkg::SIZE_W-1:0]   in_size_r;
  logic [brc_pkg::SIZE_W-1:0]   dst_size_r;
  logic [brc_pkg::STRIDE_W-1:0] stride_r;
  logic [brc_pkg::SIZE_W-1:0]   size_clamped;

  logic                         en;
  logic                         skid_full;
  logic [brc_pkg::SIZE_W-1:0]   dvs;
  logic [PRE_W-1:0]             pre;
  logic                         s0_valid_r;
  logic [NUM_W-1:0]             num_r;

  logic                         c_valid [NUM_W+1];
  logic [brc_pkg::SIZE_W-1:0]   c_rem   [NUM_W+1];
  logic [NUM_W-1:0]             c_q     [NUM_W+1];

  logic [NUM_W-1:0]             pos;
  logic [NUM_W-1:0]             d;
  logic [REF_W-1:0]             ref_nxt;
  logic [S:0]                   wgt_nxt;
  logic                         post_valid_r;
  logic [REF_W-1:0]             ref_r;
  logic [S:0]                   wgt_r;

  // Clamp a written size to the largest supported size
  always_comb begin
    if ({1'b0, cfg_wdata} > (brc_pkg::SIZE_W + 1)'(MAX_SIZE)) begin
      size_clamped = brc_pkg::SIZE_W'(MAX_SIZE);
    end else begin
      size_clamped = cfg_wdata;
    end
  end

  // Decode configuration writes; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_size_r  <= brc_pkg::SIZE_W'(8);
      dst_size_r <= brc_pkg::SIZE_W'(5);
      stride_r   <= brc_pkg::STRIDE_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        brc_pkg::CFG_IN_SIZE:  in_size_r  <= size_clamped;
        brc_pkg::CFG_DST_SIZE: dst_size_r <= size_clamped;
        brc_pkg::CFG_STRIDE:   stride_r   <= cfg_wdata[brc_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Stall the whole chain only while the skid slot is occupied
  assign en       = !skid_full;
  assign in_stall = skid_full;
  assign dvs      = (dst_size_r == '0) ? brc_pkg::SIZE_W'(1) : dst_size_r;

  // Form the centered subpixel position times in_size
  assign pre = {in_out_index, S'(0)} | PRE_W'(HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= NUM_W'(pre) * NUM_W'(in_size_r);
    end
  end

  // Divide by the destination size, one quotient bit per cell
  assign c_valid[0] = s0_valid_r;
  assign c_rem[0]   = '0;
  assign c_q[0]     = num_r;

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    brc_div_cell #(
      .NUM_W(NUM_W),
      .DVS_W(brc_pkg::SIZE_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .dvs       (dvs),
      .prev_valid(c_valid[i]),
      .prev_rem  (c_rem[i]),
      .prev_q    (c_q[i]),
      .valid_r   (c_valid[i+1]),
      .rem_r     (c_rem[i+1]),
      .q_r       (c_q[i+1])
    );
  end

  // Split the position into reference and weight, pull back off the last pixel
  always_comb begin
    pos = c_q[NUM_W];
    d   = pos - NUM_W'(HALF);
    if (pos < NUM_W'(HALF)) begin
      ref_nxt = '0;
      wgt_nxt = (S+1)'(FULL);
    end else begin
      ref_nxt = d[NUM_W-1:S];
      wgt_nxt = (S+1)'(FULL) - {1'b0, d[S-1:0]};
    end
    if (in_size_r != '0 && ref_nxt == REF_W'(in_size_r) - REF_W'(1)) begin
      ref_nxt = (in_size_r >= brc_pkg::SIZE_W'(2)) ?
                REF_W'(in_size_r - brc_pkg::SIZE_W'(2)) : '0;
      wgt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_valid_r <= 1'b0;
    end else if (en) begin
      post_valid_r <= c_valid[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ref_r <= ref_nxt;
      wgt_r <= wgt_nxt;
    end
  end

  // Scale, saturate and buffer the result
  brc_out_skid #(
    .REF_W(REF_W)
  ) u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .pipe_valid     (post_valid_r),
    .pipe_ref       (ref_r),
    .pipe_wgt       (brc_pkg::WEIGHT_W'(wgt_r)),
    .stride         (stride_r),
    .full_r         (skid_full),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_ref_pos    (out_ref_pos),
    .out_left_weight(out_left_weight)
  );

  a_weight_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    post_valid_r |-> (wgt_r <= (S+1)'(FULL)))
    else $error("left weight above full scale");

endmodule

// ===== sv/brc_div_cell.sv =====
module brc_div_cell #(
  parameter int NUM_W = 28,
  parameter int DVS_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [DVS_W-1:0] dvs,
  input  logic             prev_valid,
  input  logic [DVS_W-1:0] prev_rem,
  input  logic [NUM_W-1:0] prev_q,
  output logic             valid_r,
  output logic [DVS_W-1:0] rem_r,
  output logic [NUM_W-1:0] q_r
);

  logic [DVS_W:0]   shifted;
  logic             ge;
  logic [DVS_W:0]   diff;
  logic [DVS_W-1:0] rem_nxt;
  logic [NUM_W-1:0] q_nxt;

  // Shift in the next dividend bit and try one subtraction
  always_comb begin
    shifted = {prev_rem, prev_q[NUM_W-1]};
    ge      = (shifted >= {1'b0, dvs});
    diff    = shifted - {1'b0, dvs};
    rem_nxt = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    q_nxt   = {prev_q[NUM_W-2:0], ge};
  end

  // Advance the item to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

endmodule

// ===== sv/brc_out_skid.sv =====
module brc_out_skid #(
  parameter int REF_W = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pipe_valid,
  input  logic [REF_W-1:0]              pipe_ref,
  input  logic [brc_pkg::WEIGHT_W-1:0]  pipe_wgt,
  input  logic [brc_pkg::STRIDE_W-1:0]  stride,
  output logic                          full_r,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [brc_pkg::POS_W-1:0]     out_ref_pos,
  output logic [brc_pkg::WEIGHT_W-1:0]  out_left_weight
);

  localparam int PROD_W = REF_W + brc_pkg::STRIDE_W;

  logic [PROD_W-1:0]    scaled;
  brc_pkg::brc_result_t res;
  brc_pkg::brc_result_t main_r;
  brc_pkg::brc_result_t skid_r;
  logic                 main_valid_r;
  logic                 incoming;
  logic                 take;

  // Scale the reference by the stride and saturate to the field
  always_comb begin
    scaled = PROD_W'(pipe_ref) * PROD_W'(stride);
    if (scaled > PROD_W'(brc_pkg::POS_SAT)) begin
      res.ref_pos = brc_pkg::POS_SAT;
    end else begin
      res.ref_pos = scaled[brc_pkg::POS_W-1:0];
    end
    res.left_weight = pipe_wgt;
  end

  assign incoming = pipe_valid && !full_r;
  assign take     = main_valid_r && !out_stall;

  // Hold the result in the output register, park one more in the skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      full_r       <= 1'b0;
    end else if (!main_valid_r || take) begin
      if (full_r) begin
        main_valid_r <= 1'b1;
        full_r       <= 1'b0;
      end else begin
        main_valid_r <= incoming;
      end
    end else if (incoming) begin
      full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || take) begin
      main_r <= full_r ? skid_r : res;
    end else if (incoming) begin
      skid_r <= res;
    end
  end

  assign out_valid       = main_valid_r;
  assign out_ref_pos     = main_r.ref_pos;
  assign out_left_weight = main_r.left_weight;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> main_valid_r)
    else $error("skid slot holds an item while the output register is empty");

  a_stalled_arrival_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (main_valid_r && out_stall && incoming) |=> full_r)
    else $error("item arriving under stall was not parked");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !full_r && !incoming) |=> !main_valid_r)
    else $error("output register kept an item that was taken");

endmodule
